FILE: rtl/dda_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the DDA line rasterizer.
// No dependencies; every other file in rtl imports this package.
package dda_pkg;

    // Widest coordinate the ports carry.
    localparam int COORD_W = 6;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One input beat: a line segment given by its two endpoints.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } line_in_t;

    // One output beat: a plotted pixel.
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_pixel;
    } pixel_out_t;

    // A classified line, as queued for the stepping engine.
    typedef struct packed {
        logic [COORD_W-1:0]        x0;
        logic [COORD_W-1:0]        y0;
        logic signed [COORD_W:0]   dx;
        logic signed [COORD_W:0]   dy;
        logic [COORD_W-1:0]        steps;
    } line_job_t;

endpackage

FILE: rtl/dda_front.sv
`timescale 1ns / 1ps
// Front end: accepts a segment, masks it to the coordinate width and works out
// the signed deltas and the step count. Depends on dda_pkg.
module dda_front
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  logic      start,
    input  line_in_t  segment,
    input  logic      queue_full,
    output logic      busy,
    output logic      push,
    output line_job_t job
);

    localparam logic [COORD_W-1:0] CoordMask = COORD_W'((1 << COORD_BITS) - 1);

    logic [COORD_W-1:0]      x0;
    logic [COORD_W-1:0]      y0;
    logic [COORD_W-1:0]      x1;
    logic [COORD_W-1:0]      y1;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W-1:0]      adx;
    logic [COORD_W-1:0]      ady;

    always_comb
    begin
        x0  = segment.start_x & CoordMask;
        y0  = segment.start_y & CoordMask;
        x1  = segment.end_x & CoordMask;
        y1  = segment.end_y & CoordMask;
        dx  = signed'({1'b0, x1}) - signed'({1'b0, x0});
        dy  = signed'({1'b0, y1}) - signed'({1'b0, y0});
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

        job.x0    = x0;
        job.y0    = y0;
        job.dx    = dx;
        job.dy    = dy;
        job.steps = (adx > ady) ? adx : ady;
    end

    assign busy = queue_full;
    assign push = start && !queue_full;

endmodule

FILE: rtl/dda_queue.sv
`timescale 1ns / 1ps
// Short queue of classified lines between the front and the back.
// Depends on dda_pkg for the entry type and depth.
module dda_queue
    import dda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_job_t push_data,
    input  logic      pop,
    output line_job_t pop_data,
    output logic      full,
    output logic      empty
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthCount = CntW'(QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr    = PtrW'(QUEUE_DEPTH - 1);

    line_job_t         mem [QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;

    assign full     = (count_reg == DepthCount);
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/dda_back.sv
`timescale 1ns / 1ps
// Back end: steps one queued line a pixel per cycle with exact error
// accumulators and drives the registered pixel strobe. Depends on dda_pkg.
module dda_back
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_empty,
    input  line_job_t  job,
    output logic       pop,
    output logic       pixel_valid,
    output pixel_out_t pixel
);

    // Residues lie in [0, 2*steps); a residue plus twice a delta needs two
    // bits above the coordinate and a sign bit.
    localparam int ErrW = COORD_BITS + 3;

    typedef struct packed {
        logic [COORD_W-1:0]     coord;
        logic signed [ErrW-1:0] err;
    } axis_t;

    logic                   active_reg;
    logic                   active_next;
    logic [COORD_W-1:0]     remain_reg;
    logic [COORD_W-1:0]     remain_next;
    axis_t                  x_reg;
    axis_t                  x_next;
    axis_t                  y_reg;
    axis_t                  y_next;
    logic signed [ErrW-1:0] dx2_reg;
    logic signed [ErrW-1:0] dx2_next;
    logic signed [ErrW-1:0] dy2_reg;
    logic signed [ErrW-1:0] dy2_next;
    logic signed [ErrW-1:0] d2_reg;
    logic signed [ErrW-1:0] d2_next;
    logic                   valid_reg;
    pixel_out_t             pixel_reg;
    logic                   last_now;
    logic signed [ErrW-1:0] start_err;

    // Advance one axis: add twice the delta to the residue and carry at most
    // one unit into the coordinate.
    function automatic axis_t axis_step(axis_t cur, logic signed [ErrW-1:0] d2x,
                                        logic signed [ErrW-1:0] den);
        axis_t                  res;
        logic signed [ErrW-1:0] sum;
        sum = cur.err + d2x;
        res = cur;
        res.err = sum;
        if (!d2x[ErrW-1])
        begin
            if (sum >= den)
            begin
                res.coord = cur.coord + 1'b1;
                res.err   = sum - den;
            end
        end
        else if (sum[ErrW-1])
        begin
            res.coord = cur.coord - 1'b1;
            res.err   = sum + den;
        end
        return res;
    endfunction

    assign last_now  = (remain_reg == '0);
    assign pop       = !queue_empty && (!active_reg || last_now);
    assign start_err = signed'(ErrW'(job.steps));

    always_comb
    begin
        active_next = active_reg;
        remain_next = remain_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        dx2_next    = dx2_reg;
        dy2_next    = dy2_reg;
        d2_next     = d2_reg;
        if (pop)
        begin
            // Point zero is the start itself with a residue of half the divisor.
            active_next = 1'b1;
            remain_next = job.steps;
            x_next.coord = job.x0;
            x_next.err   = start_err;
            y_next.coord = job.y0;
            y_next.err   = start_err;
            dx2_next    = signed'(ErrW'(job.dx)) <<< 1;
            dy2_next    = signed'(ErrW'(job.dy)) <<< 1;
            d2_next     = start_err <<< 1;
        end
        else if (active_reg)
        begin
            if (last_now)
            begin
                active_next = 1'b0;
            end
            else
            begin
                remain_next = remain_reg - 1'b1;
                x_next      = axis_step(x_reg, dx2_reg, d2_reg);
                y_next      = axis_step(y_reg, dy2_reg, d2_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        dx2_reg    <= dx2_next;
        dy2_reg    <= dy2_next;
        d2_reg     <= d2_next;
        pixel_reg.pixel_x    <= x_reg.coord;
        pixel_reg.pixel_y    <= y_reg.coord;
        pixel_reg.last_pixel <= last_now;
    end

    assign pixel_valid = valid_reg;
    assign pixel       = pixel_reg;

endmodule

FILE: rtl/dda_line_rasterizer.sv
`timescale 1ns / 1ps
// DDA line rasterizer: a line of S = max(|dx|, |dy|) steps gives S + 1 pixel beats.
// A segment goes via the queue and the stepping registers to the pixel register.
// Throughput: one pixel per cycle while a line is drawn, set by the stepping engine.
// Reset (rst_n, async, active low) empties the queue and stops any line in flight.
// Pixels leave on a one-cycle strobe; the receiver cannot stall the block.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  logic       clk,
    input  logic       rst_n,
    // Command side: a segment beat is taken when start is high and busy is low.
    input  logic       start,
    input  line_in_t   segment,
    output logic       busy,
    // Result side: one pixel beat per cycle in which pixel_valid is high.
    output logic       pixel_valid,
    output pixel_out_t pixel
);

    // The front end masks the endpoints and classifies the line into signed
    // deltas and a step count. It stalls only when the queue is full, so a
    // new segment can be taken while the back end is still drawing.
    line_job_t front_job;
    logic      front_push;
    logic      queue_full;
    logic      queue_empty;
    line_job_t queue_job;
    logic      back_pop;

    dda_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .start      (start),
        .segment    (segment),
        .queue_full (queue_full),
        .busy       (busy),
        .push       (front_push),
        .job        (front_job)
    );

    // Two-entry queue decouples classification from drawing.
    dda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_job),
        .pop       (back_pop),
        .pop_data  (queue_job),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // The back end walks the line with exact rounding: each axis keeps its
    // coordinate and a residue against a divisor of twice the step count,
    // which reproduces round-half-up of start + i * delta / steps. It picks
    // up the next line in the same cycle that it registers the last pixel, so
    // consecutive lines run without a gap.
    dda_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .job         (queue_job),
        .pop         (back_pop),
        .pixel_valid (pixel_valid),
        .pixel       (pixel)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DDA line rasterizer (dda_line_rasterizer).
// Depends on rtl/dda_pkg.sv and rtl/dda_line_rasterizer.sv; reads no files.
module tb_top;
    import dda_pkg::*;

    // Coordinate width the block is built with. The ports are this wide, so
    // no endpoint bit is ever masked off.
    localparam int COORD_BITS = 6;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    // Cycles with neither a segment nor a pixel beat before the run is
    // declared hung. The longest legal quiet stretch is the longest
    // sender gap plus the trip of a new segment through the block.
    localparam int IDLE_LIMIT = 2000;

    // Cycles to keep watching after the last expected pixel has arrived.
    localparam int TAIL_CYCLES = 8;

    localparam int RANDOM_SEGMENTS = 360;
    localparam int PHASE_LEN = 40;

    // The pixel tracker holds the pixels that accepted segments must still
    // produce, in the order the block has to emit them. It works out each
    // line on its own and keeps a few totals for the closing summary.
    class pixel_tracker;
        pixel_out_t expected_pixels[$];
        int         mismatches;
        int         segments_seen;
        int         pixels_checked;
        int         zero_length_lines;
        int         longest_line;

        function new();
            mismatches        = 0;
            segments_seen     = 0;
            pixels_checked    = 0;
            zero_length_lines = 0;
            longest_line      = 0;
        endfunction

        // One coordinate of point i on a line from a with signed extent d over
        // the given step count. The exact value a + i*d/steps is rounded half
        // up; the numerator never goes negative since the point lies between
        // two non-negative endpoints.
        function logic [COORD_W-1:0] round_coord(int a, int d, int i, int steps);
            int num;
            int q;
            num = a * steps + i * d;
            q   = (2 * num + steps) / (2 * steps);
            return q[COORD_BITS-1:0];
        endfunction

        // Queue every pixel of the line from the first endpoint to the second,
        // both ends included. The step count is the larger of |dx| and |dy|.
        function void plot_line(line_in_t seg);
            int         x0, y0, dx, dy, steps;
            pixel_out_t pix;
            x0    = int'(seg.start_x);
            y0    = int'(seg.start_y);
            dx    = int'(seg.end_x) - x0;
            dy    = int'(seg.end_y) - y0;
            steps = (dx < 0 ? -dx : dx);
            if ((dy < 0 ? -dy : dy) > steps)
            begin
                steps = (dy < 0 ? -dy : dy);
            end
            if (steps > longest_line)
            begin
                longest_line = steps;
            end
            if (steps == 0)
            begin
                // A degenerate line still plots its single point.
                zero_length_lines++;
                pix.pixel_x    = seg.start_x;
                pix.pixel_y    = seg.start_y;
                pix.last_pixel = 1'b1;
                expected_pixels.push_back(pix);
                return;
            end
            for (int i = 0; i <= steps; i++)
            begin
                pix.pixel_x    = round_coord(x0, dx, i, steps);
                pix.pixel_y    = round_coord(y0, dy, i, steps);
                pix.last_pixel = (i == steps);
                expected_pixels.push_back(pix);
            end
        endfunction

        function void note_segment(line_in_t seg);
            segments_seen++;
            plot_line(seg);
        endfunction

        // Compare one pixel beat with the oldest pixel still owed.
        function void check_pixel(pixel_out_t got);
            pixel_out_t want;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected pixel x=%0d y=%0d last=%0b, none pending",
                         $time, got.pixel_x, got.pixel_y, got.last_pixel);
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.pixel_x !== want.pixel_x)
            begin
                mismatches++;
                $display("%0t: pixel_x expected %0d, got %0d",
                         $time, want.pixel_x, got.pixel_x);
            end
            if (got.pixel_y !== want.pixel_y)
            begin
                mismatches++;
                $display("%0t: pixel_y expected %0d, got %0d",
                         $time, want.pixel_y, got.pixel_y);
            end
            if (got.last_pixel !== want.last_pixel)
            begin
                mismatches++;
                $display("%0t: last_pixel expected %0b, got %0b",
                         $time, want.last_pixel, got.last_pixel);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    line_in_t   segment;
    logic       busy;
    logic       pixel_valid;
    pixel_out_t pixel;

    pixel_tracker tracker = new();
    int           idle_cycles;

    dda_line_rasterizer #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .segment     (segment),
        .busy        (busy),
        .pixel_valid (pixel_valid),
        .pixel       (pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Everything is sampled at the rising edge. Inputs only move at the
    // falling edge and the block's outputs update after the edge, so the
    // values seen here are the ones the block itself acted on.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                tracker.note_segment(segment);
            end
            if (pixel_valid)
            begin
                tracker.check_pixel(pixel);
            end
        end
    end

    // Watchdog: any segment or pixel beat counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || pixel_valid)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Idle time before the next segment. Most gaps are short, a few are
    // long, so that the block can sometimes drain completely.
    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [COORD_W-1:0] near_coord(int c);
        int v;
        v = c + $urandom_range(0, 6) - 3;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        return v[COORD_W-1:0];
    endfunction

    // Random segment: mostly endpoints anywhere on the grid, with a share of
    // short lines and zero-length lines so that the end-of-line flag and the
    // back-to-back handover between lines get plenty of traffic.
    function automatic line_in_t make_segment();
        line_in_t seg;
        int       r;
        seg.start_x = COORD_W'($urandom_range(0, COORD_MAX));
        seg.start_y = COORD_W'($urandom_range(0, COORD_MAX));
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            seg.end_x = seg.start_x;
            seg.end_y = seg.start_y;
        end
        else if (r < 35)
        begin
            seg.end_x = near_coord(int'(seg.start_x));
            seg.end_y = near_coord(int'(seg.start_y));
        end
        else
        begin
            seg.end_x = COORD_W'($urandom_range(0, COORD_MAX));
            seg.end_y = COORD_W'($urandom_range(0, COORD_MAX));
        end
        return seg;
    endfunction

    // Present one segment beat after an optional gap and hold it until the
    // block takes it. Returns at the falling edge after acceptance, with
    // start still high so a following beat can go out with no bubble.
    task automatic send_segment(input line_in_t seg, input int gap);
        if (gap > 0)
        begin
            start   = 1'b0;
            segment = line_in_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        segment = seg;
        start   = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
    endtask

    task automatic send_line(input int x0, input int y0, input int x1, input int y1,
                             input int gap);
        line_in_t seg;
        seg.start_x = x0[COORD_W-1:0];
        seg.start_y = y0[COORD_W-1:0];
        seg.end_x   = x1[COORD_W-1:0];
        seg.end_y   = y1[COORD_W-1:0];
        send_segment(seg, gap);
    endtask

    // Stop sending until every owed pixel has been seen.
    task automatic drain_pixels();
        start   = 1'b0;
        segment = line_in_t'($urandom);
        while (tracker.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        bit no_idle;

        rst_n       = 1'b0;
        start       = 1'b0;
        segment     = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed lines. Zero-length lines at both grid corners, the full
        // horizontal, vertical and diagonal spans in both directions (these
        // drive every endpoint bit both ways and give the longest line), and
        // lines whose midpoint falls exactly on a half so the round-half-up
        // rule is exercised in rising and falling directions.
        send_line(0, 0, 0, 0, 2);
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_line(0, 0, COORD_MAX, COORD_MAX, 0);
        send_line(COORD_MAX, COORD_MAX, 0, 0, 0);
        send_line(0, COORD_MAX, COORD_MAX, 0, 1);
        send_line(COORD_MAX, 0, 0, COORD_MAX, 0);
        send_line(0, 5, COORD_MAX, 5, 0);
        send_line(COORD_MAX, 40, 0, 40, 3);
        send_line(7, 0, 7, COORD_MAX, 0);
        send_line(21, COORD_MAX, 21, 0, 0);
        send_line(0, 0, 2, 1, 0);
        send_line(0, 1, 2, 0, 0);
        send_line(2, 1, 0, 0, 0);
        send_line(1, 0, 0, 2, 0);
        send_line(10, 10, 13, 11, 0);
        send_line(30, 30, 25, 33, 0);
        send_line(0, 0, 1, 1, 0);
        send_line(0, 0, 1, 0, 0);
        send_line(0, 0, 3, COORD_MAX, 0);
        send_line(COORD_MAX, 0, 0, 1, 0);
        send_line(42, 21, 21, 42, 0);

        // Let the block go fully idle once before the random traffic.
        drain_pixels();

        // Random segments in phases that alternate between bursts with no
        // idling at all and stretches with random gaps.
        for (int n = 0; n < RANDOM_SEGMENTS; n++)
        begin
            no_idle = ((n / PHASE_LEN) % 2) == 1;
            if (n == RANDOM_SEGMENTS / 2)
            begin
                drain_pixels();
            end
            send_segment(make_segment(), pick_gap(no_idle));
        end
        start   = 1'b0;
        segment = line_in_t'($urandom);

        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d segments and %0d pixel beats; %0d zero-length lines,",
                 tracker.segments_seen, tracker.pixels_checked,
                 tracker.zero_length_lines);
        $display("longest line %0d steps, with back-to-back and gapped segment beats.",
                 tracker.longest_line);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
